[rtl/adsr_pkg.sv]
`timescale 1ns / 1ps

package adsr_pkg;

    // Fixed field widths
    localparam int TRIG_W      = 16;
    localparam int ENV_W       = 18;
    localparam int LEVEL_W     = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    // Click gain is Q1.15
    localparam int GAIN_FRAC   = 15;
    localparam int GAIN_ROUND  = (1 << GAIN_FRAC) - 1;

    // Output saturation limits (magnitudes)
    localparam int ENV_POS_MAX = (1 << (ENV_W - 1)) - 1;
    localparam int ENV_NEG_MAG = 1 << (ENV_W - 1);

    // Register reset values
    localparam int ATTACK_RESET  = 441;
    localparam int DECAY_RESET   = 2205;
    localparam int SUSTAIN_RESET = 4410;
    localparam int RELEASE_RESET = 4410;
    localparam int LEVEL1_RESET  = 22938;
    localparam int LEVEL2_RESET  = 3277;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ATTACK  = 3'd0,
        REG_DECAY   = 3'd1,
        REG_SUSTAIN = 3'd2,
        REG_RELEASE = 3'd3,
        REG_LEVEL1  = 3'd4,
        REG_LEVEL2  = 3'd5,
        REG_MUTE    = 3'd6
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SELECT,
        ST_MUL_FIRST,
        ST_MUL_SECOND,
        ST_DIV_LOAD,
        ST_DIVIDE,
        ST_SCALE,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic select;
        logic mul_first;
        logic mul_second;
        logic div_load;
        logic div_step;
        logic scale;
        logic finish;
    } adsr_cmd_t;

    typedef struct packed {
        logic mute;
        logic out_free;
    } adsr_status_t;

endpackage

[rtl/adsr_if.sv]
`timescale 1ns / 1ps

interface adsr_trig_if import adsr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [TRIG_W-1:0] trigger_level;

    modport source (output valid, output trigger_level, input ready);
    modport sink   (input valid, input trigger_level, output ready);
endinterface

interface adsr_env_if import adsr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ENV_W-1:0] envelope_sample;

    modport source (output valid, output envelope_sample, input ready);
    modport sink   (input valid, input envelope_sample, output ready);
endinterface

interface adsr_cfg_if import adsr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/adsr_ctrl.sv]
`timescale 1ns / 1ps

module adsr_ctrl import adsr_pkg::*; #(
    parameter int QUOT_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  adsr_status_t status,
    output adsr_cmd_t    cmd
);

    localparam int CW = $clog2(QUOT_BITS);

    ctrl_state_t   state_reg, state_next;
    logic [CW-1:0] div_cnt_reg, div_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.mute ? ST_FINISH : ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                cmd.select = 1'b1;
                state_next = ST_MUL_FIRST;
            end
            ST_MUL_FIRST:
            begin
                cmd.mul_first = 1'b1;
                state_next    = ST_MUL_SECOND;
            end
            ST_MUL_SECOND:
            begin
                cmd.mul_second = 1'b1;
                state_next     = ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == CW'(QUOT_BITS - 1))
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/adsr_datapath.sv]
`timescale 1ns / 1ps

module adsr_datapath import adsr_pkg::*; #(
    parameter int SEGMENT_BITS  = 20,
    parameter int FRACTION_BITS = 15
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  adsr_cmd_t                cmd,
    output adsr_status_t             status,
    input  logic signed [TRIG_W-1:0] trigger_level,
    input  logic                     cfg_valid,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [ENV_W-1:0]  envelope_sample
);

    localparam int SW  = SEGMENT_BITS;
    localparam int CTW = SEGMENT_BITS + 3;
    localparam int QW  = FRACTION_BITS + 1;
    localparam int NW  = SW + QW;
    localparam int LW  = (SW < CFG_DATA_W) ? SW : CFG_DATA_W;
    localparam int SCW = QW + TRIG_W;
    localparam int RW  = SCW + 1 - GAIN_FRAC;
    localparam int MW  = (RW > ENV_W) ? RW : ENV_W;
    localparam logic [QW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    // Configuration registers
    logic [SW-1:0]      attack_reg, decay_reg, sustain_reg, release_reg;
    logic [LEVEL_W-1:0] level1_reg, level2_reg;
    logic               mute_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= SW'(ATTACK_RESET);
            decay_reg   <= SW'(DECAY_RESET);
            sustain_reg <= SW'(SUSTAIN_RESET);
            release_reg <= SW'(RELEASE_RESET);
            level1_reg  <= LEVEL_W'(LEVEL1_RESET);
            level2_reg  <= LEVEL_W'(LEVEL2_RESET);
            mute_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ATTACK:  attack_reg  <= SW'(cfg_data[LW-1:0]);
                REG_DECAY:   decay_reg   <= SW'(cfg_data[LW-1:0]);
                REG_SUSTAIN: sustain_reg <= SW'(cfg_data[LW-1:0]);
                REG_RELEASE: release_reg <= SW'(cfg_data[LW-1:0]);
                REG_LEVEL1:  level1_reg  <= cfg_data[LEVEL_W-1:0];
                REG_LEVEL2:  level2_reg  <= cfg_data[LEVEL_W-1:0];
                REG_MUTE:    mute_reg    <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // Segment boundaries, refreshed every cycle from the registers
    logic [CTW-1:0] bound2_reg, bound3_reg, total_reg;

    always_ff @(posedge clk)
    begin
        bound2_reg <= CTW'(attack_reg) + CTW'(decay_reg);
        bound3_reg <= CTW'(attack_reg) + CTW'(decay_reg) + CTW'(sustain_reg);
        total_reg  <= (CTW'(attack_reg) + CTW'(decay_reg))
                    + (CTW'(sustain_reg) + CTW'(release_reg));
    end

    // Levels at FRACTION_BITS fraction bits
    logic [QW-1:0] level1_frac, level2_frac;

    if (FRACTION_BITS >= GAIN_FRAC)
    begin : g_level_up
        assign level1_frac = QW'(level1_reg) << (FRACTION_BITS - GAIN_FRAC);
        assign level2_frac = QW'(level2_reg) << (FRACTION_BITS - GAIN_FRAC);
    end
    else
    begin : g_level_down
        assign level1_frac = QW'(level1_reg >> (GAIN_FRAC - FRACTION_BITS));
        assign level2_frac = QW'(level2_reg >> (GAIN_FRAC - FRACTION_BITS));
    end

    // Envelope state
    logic [CTW-1:0]           counter_reg;
    logic signed [TRIG_W-1:0] gain_reg;
    logic                     muted_reg;

    // Segment selection
    logic [CTW-1:0] to_bound2, to_bound3, to_total, past_attack, past_bound2;
    logic [SW-1:0]  x1_sel, x2_sel, div_sel;
    logic [QW-1:0]  y1_sel, y2_sel;
    logic           off_sel;

    assign to_bound2   = bound2_reg - counter_reg;
    assign to_bound3   = bound3_reg - counter_reg;
    assign to_total    = total_reg - counter_reg;
    assign past_attack = counter_reg - CTW'(attack_reg);
    assign past_bound2 = counter_reg - bound2_reg;

    always_comb
    begin
        x1_sel  = '0;
        y1_sel  = '0;
        x2_sel  = '0;
        y2_sel  = '0;
        div_sel = release_reg;
        off_sel = 1'b0;
        if (counter_reg < CTW'(attack_reg))
        begin
            x1_sel  = counter_reg[SW-1:0];
            y1_sel  = ONE;
            div_sel = attack_reg;
        end
        else if (counter_reg < bound2_reg)
        begin
            x1_sel  = to_bound2[SW-1:0];
            y1_sel  = ONE;
            x2_sel  = past_attack[SW-1:0];
            y2_sel  = level1_frac;
            div_sel = decay_reg;
        end
        else if (counter_reg < bound3_reg)
        begin
            x1_sel  = to_bound3[SW-1:0];
            y1_sel  = level1_frac;
            x2_sel  = past_bound2[SW-1:0];
            y2_sel  = level2_frac;
            div_sel = sustain_reg;
        end
        else if (counter_reg < total_reg)
        begin
            x1_sel  = to_total[SW-1:0];
            y1_sel  = level2_frac;
            div_sel = release_reg;
        end
        else
        begin
            off_sel = 1'b1;
        end
    end

    logic [SW-1:0] x1_reg, x2_reg, div_reg;
    logic [QW-1:0] y1_reg, y2_reg;
    logic          off_reg;

    // Shared multiplier for the numerator terms
    logic [NW-1:0] prod;
    assign prod = cmd.mul_first ? NW'(x1_reg) * NW'(y1_reg)
                                : NW'(x2_reg) * NW'(y2_reg);

    logic [NW-1:0] num_reg;

    // Restoring divider, one quotient bit per step; remainder starts below div
    logic [SW-1:0] rem_reg;
    logic [QW-1:0] quo_reg;
    logic [SW:0]   trial, trial_diff;
    logic          trial_ge;

    assign trial      = {rem_reg, quo_reg[QW-1]};
    assign trial_ge   = trial >= {1'b0, div_reg};
    assign trial_diff = trial - {1'b0, div_reg};

    // Click gain scaling
    logic [TRIG_W-1:0] gain_abs;
    logic [QW-1:0]     env_value;
    logic [QW-1:0]     env_reg;
    logic [SCW-1:0]    mag_reg;
    logic              scaled_reg, neg_reg;

    assign gain_abs  = gain_reg[TRIG_W-1] ? (~gain_reg + 1'b1) : gain_reg;
    assign env_value = off_reg ? '0 : quo_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.select)
        begin
            x1_reg  <= x1_sel;
            y1_reg  <= y1_sel;
            x2_reg  <= x2_sel;
            y2_reg  <= y2_sel;
            div_reg <= div_sel;
            off_reg <= off_sel;
        end
        if (cmd.mul_first)
        begin
            num_reg <= prod;
        end
        if (cmd.mul_second)
        begin
            num_reg <= num_reg + prod;
        end
        if (cmd.div_load)
        begin
            rem_reg <= num_reg[NW-1:QW];
            quo_reg <= num_reg[QW-1:0];
        end
        if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_diff[SW-1:0] : trial[SW-1:0];
            quo_reg <= {quo_reg[QW-2:0], trial_ge};
        end
        if (cmd.scale)
        begin
            env_reg    <= env_value;
            mag_reg    <= SCW'(env_value) * SCW'(gain_abs);
            scaled_reg <= (gain_reg != '0) && (env_value != '0);
            neg_reg    <= gain_reg[TRIG_W-1];
        end
    end

    // Rounding toward minus infinity for negative gain, then saturation
    logic [SCW:0]      mag_sum;
    logic [RW-1:0]     rounded;
    logic [MW-1:0]     sel_mag;
    logic              neg_out;
    logic [ENV_W-1:0]  sat_value;

    assign mag_sum = {1'b0, mag_reg} + (SCW+1)'(neg_reg ? GAIN_ROUND : 0);
    assign rounded = mag_sum[SCW:GAIN_FRAC];
    assign sel_mag = scaled_reg ? MW'(rounded) : MW'(env_reg);
    assign neg_out = scaled_reg && neg_reg;

    always_comb
    begin
        if (neg_out)
        begin
            if (sel_mag > MW'(ENV_NEG_MAG))
                sat_value = ENV_W'(ENV_NEG_MAG);
            else
                sat_value = ~sel_mag[ENV_W-1:0] + 1'b1;
        end
        else
        begin
            if (sel_mag > MW'(ENV_POS_MAX))
                sat_value = ENV_W'(ENV_POS_MAX);
            else
                sat_value = sel_mag[ENV_W-1:0];
        end
    end

    // Counter and click gain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            gain_reg    <= '0;
            muted_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                muted_reg <= mute_reg;
                if (!mute_reg && trigger_level != '0)
                begin
                    gain_reg    <= trigger_level;
                    counter_reg <= '0;
                end
            end
            if (cmd.finish && !muted_reg && counter_reg < total_reg)
            begin
                counter_reg <= counter_reg + 1'b1;
            end
        end
    end

    // Output register
    logic                    out_valid_reg;
    logic signed [ENV_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg <= muted_reg ? '0 : sat_value;
        end
    end

    assign out_valid       = out_valid_reg;
    assign envelope_sample = out_data_reg;
    assign status.mute     = mute_reg;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

[rtl/adsr_envelope_generator_top.sv]
`timescale 1ns / 1ps

// One-shot ADSR envelope generator, one output word per trigger word.
// Channels:
//   trigger  - sink, one Q1.15 trigger word per audio tick. Nonzero restarts
//              the envelope and sets the click gain unless muted.
//   envelope - source, one signed Q3.15 envelope word per trigger word.
//   cfg      - register writes (index, data), always ready. Write only while
//              the block is idle.
// Sequence: an accepted word passes segment select, two multiply steps,
// divider load, the radix-2 divider, which produces one quotient bit per
// cycle, a scale step and the finish step into the output register. A new
// trigger word is accepted only after the previous one has finished.
// When muted, accept goes straight to the finish step; the output word is zero.
// Reset: registers return to their default lengths and levels, counter and
// click gain clear, output register empties.
// A stalled receiver holds the finished word in the output register; the
// next trigger word is still accepted and computed, then waits for a free
// output register before finishing.

module adsr_envelope_generator_top import adsr_pkg::*; #(
    parameter int SEGMENT_BITS  = 20,
    parameter int FRACTION_BITS = 15
) (
    input logic          clk,
    input logic          rst_n,
    adsr_trig_if.sink    trigger,
    adsr_env_if.source   envelope,
    adsr_cfg_if.sink     cfg
);

    adsr_cmd_t    cmd;
    adsr_status_t status;

    // Register writes never stall
    assign cfg.ready = 1'b1;

    // Sequencer: accept, select segment, two multiply steps, divider load, divide, scale, finish
    adsr_ctrl #(
        .QUOT_BITS (FRACTION_BITS + 1)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (trigger.valid),
        .in_ready (trigger.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Registers, counter, multiplier, divider, scaling and output register
    adsr_datapath #(
        .SEGMENT_BITS  (SEGMENT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .trigger_level   (trigger.trigger_level),
        .cfg_valid       (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .out_valid       (envelope.valid),
        .out_ready       (envelope.ready),
        .envelope_sample (envelope.envelope_sample)
    );

endmodule
